// File: rtl/core/lrk_pkg.sv
// Shared types, constants and the add-rotate mix for the lagged keystream block.
package lrk_pkg;

  // Key table geometry
  localparam int TABLE_WORDS = 17;
  localparam int LAG_START   = 10;
  // Lag word sits this many cells behind the lead word in the chain
  localparam int LAG_POS     = TABLE_WORDS - LAG_START;
  localparam int WARM_STEPS  = 9;
  // Table words produced by the seeder after the first one
  localparam int FILL_WORDS  = TABLE_WORDS - 1;
  localparam int CNT_W       = 4;

  localparam logic [31:0] SEED_MULT  = 32'h53A9_B4FB;
  localparam logic [31:0] SEED_RESET = 32'h0000_2477;

  // Per-cycle move of every cell in the chain
  typedef enum logic [1:0] {
    MODE_HOLD  = 2'd0,
    MODE_STEP1 = 2'd1,
    MODE_STEP2 = 2'd2,
    MODE_FILL  = 2'd3
  } cell_mode_t;

  // Controller state, one-hot
  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_SEED      = 6'b000010,
    ST_FILL      = 6'b000100,
    ST_FILL_LAST = 6'b001000,
    ST_WARM      = 6'b010000,
    ST_BYTE      = 6'b100000
  } ctl_state_t;

  // Controller to datapath
  typedef struct packed {
    cell_mode_t mode;
    logic       seed_from_reg;  // seeder starts from the seed register
    logic       seed_adv;       // seeder advances
    logic       hold_load;      // capture first table word
    logic       fill_from_hold; // chain takes the held first word
    logic       out_from_data;  // output word built from the stored data byte
    logic       out_load;       // output register takes a new word
  } ctl_t;

  // One generator step: rotl(a,9) + rotl(b,13)
  function automatic logic [31:0] mix(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ra;
    logic [31:0] rb;
    ra = {a[22:0], a[31:23]};
    rb = {b[18:0], b[31:19]};
    return ra + rb;
  endfunction

endpackage

// File: rtl/core/lrk_cell.sv
// One key table word of the cell chain, fed by its neighbors.
module lrk_cell
  import lrk_pkg::*;
(
  input  logic        clk,
  input  cell_mode_t  mode,
  input  logic [31:0] from_next1,
  input  logic [31:0] from_next2,
  input  logic [31:0] from_prev,
  output logic [31:0] word_o
);

  logic [31:0] word_r;

  // shift by one or two steps toward the lead, or fill from behind
  always_ff @(posedge clk) begin
    case (mode)
      MODE_STEP1: word_r <= from_next1;
      MODE_STEP2: word_r <= from_next2;
      MODE_FILL:  word_r <= from_prev;
      default:    word_r <= word_r;
    endcase
  end

  assign word_o = word_r;

endmodule

// File: rtl/core/lrk_ctrl.sv
// Sequencer for normal bytes and the reseed / fill / warm-up run.
module lrk_ctrl
  import lrk_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_restart,
  input  logic out_free,
  output logic in_ready,
  output ctl_t ctl
);

  ctl_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              accept;

  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  // next state and chain control
  always_comb begin
    state_nxt          = state_r;
    cnt_nxt            = cnt_r;
    ctl                = '0;
    ctl.mode           = MODE_HOLD;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_restart) begin
            state_nxt = ST_SEED;
          end else begin
            ctl.mode     = MODE_STEP2;
            ctl.out_load = 1'b1;
          end
        end
      end
      ST_SEED: begin
        ctl.seed_from_reg = 1'b1;
        ctl.seed_adv      = 1'b1;
        ctl.hold_load     = 1'b1;
        cnt_nxt           = '0;
        state_nxt         = ST_FILL;
      end
      ST_FILL: begin
        ctl.seed_adv = 1'b1;
        ctl.mode     = MODE_FILL;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(FILL_WORDS - 1)) begin
          state_nxt = ST_FILL_LAST;
        end
      end
      ST_FILL_LAST: begin
        ctl.mode           = MODE_FILL;
        ctl.fill_from_hold = 1'b1;
        cnt_nxt            = '0;
        state_nxt          = ST_WARM;
      end
      ST_WARM: begin
        ctl.mode = MODE_STEP1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(WARM_STEPS - 1)) begin
          state_nxt = ST_BYTE;
        end
      end
      ST_BYTE: begin
        if (out_free) begin
          ctl.mode          = MODE_STEP2;
          ctl.out_load      = 1'b1;
          ctl.out_from_data = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // a restart word always starts the seeding run
  a_restart_seeds: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_restart |=> state_r == ST_SEED)
    else $error("restart word did not start reseed");

  // double steps only for a byte, never during fill or warm-up
  a_step2_byte_only: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.mode == MODE_STEP2 |-> ctl.out_load)
    else $error("double step without output load");

  a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FILL |-> cnt_r <= CNT_W'(FILL_WORDS - 1))
    else $error("fill count overrun");

  a_warm_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WARM |-> cnt_r <= CNT_W'(WARM_STEPS - 1))
    else $error("warm-up count overrun");

endmodule

// File: rtl/core/lagged_rotate_keystream_xor.sv
// Top level: lagged add-rotate keystream generator XORed onto a byte stream.
//
// Input words (in_*) carry one data byte in in_tdata and the restart flag in
// in_tuser. Each accepted word gives exactly one output word (out_*): the byte
// XORed with one keystream byte. The seed is written on the cfg_* channel,
// which is always ready; write it only while no byte is in flight.
// A word without restart is taken while the sequencer is idle; its result is in
// the output register on the next cycle, so such bytes stream at one per cycle
// while out_tready stays high. Each output byte takes two add-rotate steps over
// the 17-cell word chain; warm-up steps are single. A word with restart goes through
// accept, seed, 16 fill words from the multiplier, placing the first word, 9
// warm-up steps and a final step that loads the result once the output is free.
// The single 32x32 seed multiplier and one-word chain fill entry set this run's length.
// Reset returns the seed to 0x2477 and the sequencer to idle; the key table is
// undefined until the first restart word. When out_tready is low the result
// holds in the output register and no new input word is taken.
module lagged_rotate_keystream_xor
  import lrk_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tuser,    // [0] restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] out_byte
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  ctl_t        ctl;
  logic        out_free;
  logic [31:0] seed_r;
  logic [31:0] s_r, s_src, s_prod, s_nxt;
  logic [31:0] hold_r;
  logic [31:0] fill_word;
  logic [7:0]  data_r;
  logic [7:0]  out_data_r;
  logic        out_valid_r;
  logic [31:0] r1, r2;
  logic [7:0]  byte_src;
  logic [31:0] word   [TABLE_WORDS];
  logic [31:0] next1  [TABLE_WORDS];
  logic [31:0] next2  [TABLE_WORDS];
  logic [31:0] prev   [TABLE_WORDS];

  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  lrk_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_restart (in_tuser),
    .out_free   (out_free),
    .in_ready   (in_tready),
    .ctl        (ctl)
  );

  // seed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      seed_r <= cfg_data;
    end
  end

  // seeder: s = 1 - s * mult
  assign s_src  = ctl.seed_from_reg ? seed_r : s_r;
  assign s_prod = s_src * SEED_MULT;
  assign s_nxt  = 32'd1 - s_prod;

  always_ff @(posedge clk) begin
    if (ctl.seed_adv) begin
      s_r <= s_nxt;
    end
    if (ctl.hold_load) begin
      hold_r <= s_nxt;
    end
  end

  assign fill_word = ctl.fill_from_hold ? hold_r : s_nxt;

  // generator steps: cell 0 holds the lead word, LAG_POS the lag word
  assign r1 = mix(word[0], word[LAG_POS]);
  assign r2 = mix(word[1], word[LAG_POS + 1]);

  // neighbor wiring of the chain
  for (genvar p = 0; p < TABLE_WORDS; p++) begin : g_chain
    if (p == TABLE_WORDS - 1) begin : g_tail
      assign next1[p] = r1;
      assign next2[p] = r2;
    end else if (p == TABLE_WORDS - 2) begin : g_pen
      assign next1[p] = word[p + 1];
      assign next2[p] = r1;
    end else begin : g_mid
      assign next1[p] = word[p + 1];
      assign next2[p] = word[p + 2];
    end
    if (p == 0) begin : g_head
      assign prev[p] = fill_word;
    end else begin : g_body
      assign prev[p] = word[p - 1];
    end

    lrk_cell u_cell (
      .clk        (clk),
      .mode       (ctl.mode),
      .from_next1 (next1[p]),
      .from_next2 (next2[p]),
      .from_prev  (prev[p]),
      .word_o     (word[p])
    );
  end

  // data byte kept over the reseed run
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      data_r <= in_tdata;
    end
  end

  assign byte_src = ctl.out_from_data ? data_r : in_tdata;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_data_r <= byte_src ^ r2[31:24];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a plain byte gives its result on the next cycle
  a_plain_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser |=> out_tvalid)
    else $error("plain byte result missing");

  // never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !ctl.out_load)
    else $error("pending result overwritten");

  // the chain only moves on idle accept or inside the reseed run
  a_chain_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && !in_tvalid |-> ctl.mode == MODE_HOLD)
    else $error("chain moved while idle");

endmodule
